### src/iscf_pkg.sv
// Package with shared types and constants for the cluster flip update block.
package iscf_pkg;

  localparam int unsigned LatticeSide = 64;

  localparam int unsigned ThrW = 17;
  localparam int unsigned SizeW = 13;
  localparam int unsigned MagW = 14;
  localparam int unsigned SiteW = 12;

  localparam logic [1:0] RegProbNear = 2'd0;
  localparam logic [1:0] RegProbFar  = 2'd1;
  localparam logic [1:0] RegRngSeed  = 2'd2;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindUpdate = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_POP,
    ST_POPWAIT,
    ST_OWN,
    ST_NBREQ,
    ST_NBEVAL,
    ST_FLIPREQ,
    ST_FLIPRD,
    ST_FLIPWR,
    ST_DONE
  } state_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

### src/iscf_if.sv
// Valid/ready channel interfaces for input items and result items.
interface iscf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [11:0] site;
  logic       spin_value;
  modport source (output valid, kind, site, spin_value, input ready);
  modport sink (input valid, kind, site, spin_value, output ready);
endinterface

interface iscf_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] cluster_size;
  logic signed [13:0] magnetization;
  modport source (output valid, cluster_size, magnetization, input ready);
  modport sink (input valid, cluster_size, magnetization, output ready);
endinterface

### src/ising_cluster_flip_update.sv
// Top level of the Wolff cluster update engine with axial next-nearest coupling.
// A load reads the site's spin and rewrites it when it differs. An update seeds a
// cluster, pops each member and tests its six neighbors through the registered-read
// spin and mark memories, then flips every member. A waiting result holds the end
// of the next update. Reset returns the controller to idle and sets the spin total
// to the site count; a clearing pass then zeroes spin and mark memories.
module ising_cluster_flip_update
  import iscf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  iscf_in_if.sink     in_ch,
  iscf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SIDE = LatticeSide;
  localparam int unsigned Sites = SIDE * SIDE;
  localparam int unsigned AW = $clog2(Sites);
  localparam int unsigned LW = $clog2(SIDE);
  localparam int unsigned CW = AW + 1;

  // Configuration registers and the random generator state.
  logic [ThrW-1:0] prob_near;
  logic [ThrW-1:0] prob_far;
  logic [31:0]     rng_seed;
  logic [31:0]     rng_state;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      RegProbNear: prdata = 32'(prob_near);
      RegProbFar:  prdata = 32'(prob_far);
      RegRngSeed:  prdata = rng_seed;
      default:     prdata = '0;
    endcase
  end

  // Memories: spin, mark, work stack and member list.
  logic spin_mem [Sites];
  logic mark_mem [Sites];
  logic [AW-1:0] stack_mem [Sites];
  logic [AW-1:0] list_mem [Sites];

  logic          spin_we, mark_we, stack_we, list_we;
  logic [AW-1:0] spin_wa, mark_wa, stack_wa, list_wa;
  logic          spin_wd, mark_wd;
  logic [AW-1:0] stack_wd, list_wd;
  logic [AW-1:0] spin_ra, mark_ra, stack_ra, list_ra;
  logic          spin_rd, mark_rd;
  logic [AW-1:0] stack_rd, list_rd;

  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_wa] <= spin_wd;
    spin_rd <= spin_mem[spin_ra];
  end
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd <= mark_mem[mark_ra];
  end
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_rd <= stack_mem[stack_ra];
  end
  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_rd <= list_mem[list_ra];
  end

  // Controller registers.
  state_t        state, state_next;
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] sp, sp_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [AW-1:0] cur, cur_next;
  logic          own, own_next;
  logic [2:0]    dir, dir_next;
  logic [MagW-1:0] spin_total, spin_total_next;
  logic [31:0]   rng_next;
  logic          out_valid, out_valid_next;
  logic [SizeW-1:0] out_size, out_size_next;
  logic [MagW-1:0] out_mag, out_mag_next;
  logic [AW-1:0] nb;

  // Neighbor address for the current direction, with periodic wrap.
  logic [LW-1:0] row, col, nrow, ncol;
  always_comb begin
    row = cur[AW-1:LW];
    col = cur[LW-1:0];
    nrow = row;
    ncol = col;
    case (dir)
      3'd0: ncol = (col == '0) ? LW'(SIDE - 1) : col - 1'b1;
      3'd1: ncol = (col == LW'(SIDE - 1)) ? '0 : col + 1'b1;
      3'd2: nrow = (row == '0) ? LW'(SIDE - 1) : row - 1'b1;
      3'd3: nrow = (row == LW'(SIDE - 1)) ? '0 : row + 1'b1;
      3'd4: nrow = (row < LW'(2)) ? LW'(SIDE - 2) + row : row - LW'(2);
      default: nrow = (row >= LW'(SIDE - 2)) ? row - LW'(SIDE - 2) : row + LW'(2);
    endcase
    nb = {nrow, ncol};
  end

  logic [31:0] draw_state;
  logic [ThrW-1:0] thr;
  logic want, accept;
  assign draw_state = xorshift32(rng_state);
  assign thr = (dir < 3'd4) ? prob_near : prob_far;
  assign want = (dir < 3'd4) ? (spin_rd == own) : (spin_rd != own);
  assign accept = {1'b0, draw_state[31:16]} < thr;

  logic in_ok;
  assign in_ok = 32'(in_ch.site) < 32'(Sites);
  assign in_ch.ready = (state == ST_IDLE) && !clearing;
  assign out_ch.valid = out_valid;
  assign out_ch.cluster_size = out_size;
  // The magnetization is captured with the size so it holds while the result waits.
  assign out_ch.magnetization = out_mag;

  always_comb begin
    state_next = state;
    sp_next = sp;
    count_next = count;
    idx_next = idx;
    cur_next = cur;
    own_next = own;
    dir_next = dir;
    spin_total_next = spin_total;
    rng_next = rng_state;
    out_valid_next = out_valid;
    out_size_next = out_size;
    out_mag_next = out_mag;
    spin_we = 1'b0; spin_wa = cur; spin_wd = 1'b0;
    mark_we = 1'b0; mark_wa = nb; mark_wd = 1'b1;
    stack_we = 1'b0; stack_wa = sp[AW-1:0]; stack_wd = nb;
    list_we = 1'b0; list_wa = count[AW-1:0]; list_wd = nb;
    spin_ra = cur; mark_ra = nb;
    stack_ra = sp[AW-1:0]; list_ra = idx[AW-1:0];
    if (out_valid && out_ch.ready) out_valid_next = 1'b0;
    if (clearing) begin
      spin_we = 1'b1; spin_wa = clr_addr; spin_wd = 1'b0;
      mark_we = 1'b1; mark_wa = clr_addr; mark_wd = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready && in_ok) begin
          cur_next = in_ch.site[AW-1:0];
          own_next = in_ch.spin_value;
          if (in_ch.kind == KindLoad) begin
            spin_ra = in_ch.site[AW-1:0];
            state_next = ST_DONE;
            idx_next = '0;
          end else begin
            state_next = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        mark_we = 1'b1; mark_wa = cur;
        stack_we = 1'b1; stack_wa = '0; stack_wd = cur;
        list_we = 1'b1; list_wa = '0; list_wd = cur;
        sp_next = CW'(1);
        count_next = CW'(1);
        state_next = ST_POP;
      end
      ST_POP: begin
        if (sp == '0) begin
          idx_next = '0;
          state_next = ST_FLIPREQ;
        end else begin
          sp_next = sp - 1'b1;
          stack_ra = sp_next[AW-1:0];
          state_next = ST_POPWAIT;
        end
      end
      ST_POPWAIT: begin
        cur_next = stack_rd;
        spin_ra = stack_rd;
        state_next = ST_OWN;
      end
      ST_OWN: begin
        own_next = spin_rd;
        dir_next = '0;
        state_next = ST_NBREQ;
      end
      ST_NBREQ: begin
        spin_ra = nb; mark_ra = nb;
        state_next = ST_NBEVAL;
      end
      ST_NBEVAL: begin
        if (want && !mark_rd) begin
          rng_next = draw_state;
          if (accept && sp < CW'(Sites) && count < CW'(Sites)) begin
            mark_we = 1'b1;
            stack_we = 1'b1;
            list_we = 1'b1;
            sp_next = sp + 1'b1;
            count_next = count + 1'b1;
          end
        end
        if (dir == 3'd5) begin
          state_next = ST_POP;
        end else begin
          dir_next = dir + 1'b1;
          state_next = ST_NBREQ;
        end
      end
      ST_FLIPREQ: begin
        if (idx == count) begin
          out_size_next = SizeW'(count);
          out_mag_next = spin_total;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FLIPRD;
        end
      end
      ST_FLIPRD: begin
        cur_next = list_rd;
        spin_ra = list_rd;
        state_next = ST_FLIPWR;
      end
      ST_FLIPWR: begin
        spin_we = 1'b1; spin_wa = cur; spin_wd = !spin_rd;
        mark_we = 1'b1; mark_wa = cur; mark_wd = 1'b0;
        spin_total_next = spin_rd ? spin_total + MagW'(2) : spin_total - MagW'(2);
        idx_next = idx + 1'b1;
        list_ra = idx_next[AW-1:0];
        state_next = ST_FLIPREQ;
      end
      ST_DONE: begin
        // Load: spin of the site is now on the read port.
        if (spin_rd != own) begin
          spin_we = 1'b1; spin_wa = cur; spin_wd = own;
          spin_total_next = own ? spin_total - MagW'(2) : spin_total + MagW'(2);
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    // The result register must be free before a new update may report.
    if (state == ST_FLIPREQ && idx == count && out_valid && !out_ch.ready) begin
      state_next = ST_FLIPREQ;
      out_valid_next = 1'b1;
      out_size_next = out_size;
      out_mag_next = out_mag;
    end
    // A seed write reloads the generator; a zero seed would lock it, so it loads one.
    if (cfg_wr && paddr[3:2] == RegRngSeed) begin
      rng_next = (pwdata == '0) ? 32'd1 : pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      out_valid <= 1'b0;
      spin_total <= MagW'(Sites);
      prob_near <= '0;
      prob_far <= '0;
      rng_seed <= 32'd1;
      rng_state <= 32'd1;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      spin_total <= spin_total_next;
      rng_state <= rng_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(Sites - 1)) clearing <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          RegProbNear: prob_near <= pwdata[ThrW-1:0];
          RegProbFar:  prob_far <= pwdata[ThrW-1:0];
          RegRngSeed:  rng_seed <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sp <= sp_next;
    count <= count_next;
    idx <= idx_next;
    cur <= cur_next;
    own <= own_next;
    dir <= dir_next;
    out_size <= out_size_next;
    out_mag <= out_mag_next;
  end

endmodule
